@@ rtl/core/dmct_pkg.sv @@
// Shared types and constants for the direct-mapped cache tag model.
package dmct_pkg;

  localparam int LINE_BYTES_DEF  = 4;
  localparam int CACHE_BYTES_DEF = 8192;
  localparam int ADDR_BITS_DEF   = 32;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 32;
  localparam int PEN_W  = 8;
  localparam int CNT_W  = 32;
  localparam int CFG_W  = 1;

  localparam logic [PEN_W-1:0] PENALTY_RESET = PEN_W'(12);

  // configuration register indexes
  localparam logic [CFG_W-1:0] CFG_READ_MISS_PENALTY = 1'b0;
  localparam logic [CFG_W-1:0] CFG_WRITE_PENALTY     = 1'b1;

  // op code 3 is treated as a store
  typedef enum logic [OP_W-1:0] {
    OP_FETCH = 2'd0,
    OP_LOAD  = 2'd1,
    OP_STORE = 2'd2
  } op_t;

  // outcome of one lookup, handed to the statistics stage
  typedef struct packed {
    logic             is_read;
    logic             is_fetch;
    logic             hit;
    logic [PEN_W-1:0] stall;
  } dmct_event_t;

endpackage

@@ rtl/core/direct_mapped_cache_tag_model.sv @@
// Top level of the direct-mapped write-through write-around cache tag model.
//
// Sustains one access per clock while the output is not stalled: an access is looked
// up in the tag RAM in the cycle after it is accepted, and its result is registered
// into the output register once the output can take it. The tag RAM has one read and
// one write port; a line fill is written back while the next access reads, and a fill
// to the same line is forwarded. After reset the block sweeps the tag RAM to clear
// every valid bit, one line per cycle over all CACHE_BYTES/LINE_BYTES lines (2048 by
// default), and takes no access until the sweep is done; configuration writes are
// taken at any time.
// LINE_BYTES and CACHE_BYTES must be powers of two with at least two lines.
module direct_mapped_cache_tag_model #(
  parameter int LINE_BYTES  = dmct_pkg::LINE_BYTES_DEF,
  parameter int CACHE_BYTES = dmct_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = dmct_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [dmct_pkg::CFG_W-1:0]    cfg_index,
  input  logic [dmct_pkg::PEN_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dmct_pkg::OP_W-1:0]     op,
  input  logic [dmct_pkg::ADDR_W-1:0]   address,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [dmct_pkg::PEN_W-1:0]    stall_cycles,
  output logic [dmct_pkg::CNT_W-1:0]    read_hit_count,
  output logic [dmct_pkg::CNT_W-1:0]    read_miss_count,
  output logic [dmct_pkg::CNT_W-1:0]    write_hit_count,
  output logic [dmct_pkg::CNT_W-1:0]    write_miss_count,
  output logic [dmct_pkg::CNT_W-1:0]    read_stall_total,
  output logic [dmct_pkg::CNT_W-1:0]    write_stall_total,
  output logic [dmct_pkg::CNT_W-1:0]    fetch_count
);

  logic [dmct_pkg::PEN_W-1:0] read_miss_penalty;
  logic [dmct_pkg::PEN_W-1:0] write_penalty;
  logic                       evt_valid;
  logic                       evt_ready;
  dmct_pkg::dmct_event_t      evt;

  always_ff @(posedge clk) begin
    if (rst) begin
      read_miss_penalty <= dmct_pkg::PENALTY_RESET;
      write_penalty     <= dmct_pkg::PENALTY_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        dmct_pkg::CFG_READ_MISS_PENALTY: read_miss_penalty <= cfg_data;
        dmct_pkg::CFG_WRITE_PENALTY:     write_penalty     <= cfg_data;
        default: ;
      endcase
    end
  end

  dmct_tag_ctrl #(
    .LINE_BYTES  (LINE_BYTES),
    .CACHE_BYTES (CACHE_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) u_tag_ctrl (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .op                (op),
    .address           (address),
    .read_miss_penalty (read_miss_penalty),
    .write_penalty     (write_penalty),
    .evt_valid         (evt_valid),
    .evt_ready         (evt_ready),
    .evt               (evt)
  );

  dmct_stats u_stats (
    .clk               (clk),
    .rst               (rst),
    .evt_valid         (evt_valid),
    .evt_ready         (evt_ready),
    .evt               (evt),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .hit               (hit),
    .stall_cycles      (stall_cycles),
    .read_hit_count    (read_hit_count),
    .read_miss_count   (read_miss_count),
    .write_hit_count   (write_hit_count),
    .write_miss_count  (write_miss_count),
    .read_stall_total  (read_stall_total),
    .write_stall_total (write_stall_total),
    .fetch_count       (fetch_count)
  );

endmodule

@@ rtl/core/dmct_ram.sv @@
// Generic simple dual-port RAM with registered read (read-old on collision).
module dmct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/dmct_tag_ctrl.sv @@
// Tag store control: clearing sweep, lookup, line fill and write-back forwarding.
module dmct_tag_ctrl #(
  parameter int LINE_BYTES  = dmct_pkg::LINE_BYTES_DEF,
  parameter int CACHE_BYTES = dmct_pkg::CACHE_BYTES_DEF,
  parameter int ADDR_BITS   = dmct_pkg::ADDR_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [dmct_pkg::OP_W-1:0]     op,
  input  logic [dmct_pkg::ADDR_W-1:0]   address,
  input  logic [dmct_pkg::PEN_W-1:0]    read_miss_penalty,
  input  logic [dmct_pkg::PEN_W-1:0]    write_penalty,
  output logic                          evt_valid,
  input  logic                          evt_ready,
  output dmct_pkg::dmct_event_t         evt
);

  localparam int NUM_LINES = CACHE_BYTES / LINE_BYTES;
  localparam int OFF_W     = $clog2(LINE_BYTES);
  localparam int IDX_W     = $clog2(NUM_LINES);
  localparam int TAG_SHIFT = OFF_W + IDX_W;
  localparam int TAG_W     = (ADDR_BITS > TAG_SHIFT) ? ADDR_BITS - TAG_SHIFT : 1;
  localparam int ENTRY_W   = TAG_W + 1;
  localparam logic [dmct_pkg::ADDR_W-1:0] ADDR_MASK =
    dmct_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
  localparam logic [IDX_W-1:0] LAST_LINE = IDX_W'(NUM_LINES - 1);

  logic                          clearing;
  logic [IDX_W-1:0]              clear_ptr;
  logic                          s1_valid;
  logic [dmct_pkg::OP_W-1:0]     s1_op;
  logic [IDX_W-1:0]              s1_idx;
  logic [TAG_W-1:0]              s1_tag;
  logic                          fwd_valid;
  logic [IDX_W-1:0]              fwd_idx;
  logic [TAG_W-1:0]              fwd_tag;

  logic [dmct_pkg::ADDR_W-1:0]   addr_masked;
  logic [IDX_W-1:0]              in_idx;
  logic [TAG_W-1:0]              in_tag;
  logic                          accept;
  logic                          advance;
  logic                          fill;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [ENTRY_W-1:0]            ram_wdata;
  logic [ENTRY_W-1:0]            ram_rdata;
  logic                          line_valid;
  logic [TAG_W-1:0]              line_tag;
  logic                          hit;
  logic                          is_read;

  assign addr_masked = address & ADDR_MASK;
  assign in_idx      = IDX_W'(addr_masked >> OFF_W);
  assign in_tag      = TAG_W'({32'd0, addr_masked} >> TAG_SHIFT);

  assign in_ready = !clearing && (!s1_valid || evt_ready);
  assign accept   = in_valid && in_ready;
  assign advance  = s1_valid && evt_ready;

  dmct_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_LINES)
  ) u_tag_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  // a fill landing in the same cycle as the read is not seen by the RAM
  always_comb begin
    if (fwd_valid && (fwd_idx == s1_idx)) begin
      line_valid = 1'b1;
      line_tag   = fwd_tag;
    end else begin
      line_valid = ram_rdata[ENTRY_W-1];
      line_tag   = ram_rdata[TAG_W-1:0];
    end
  end

  assign hit     = line_valid && (line_tag == s1_tag);
  assign is_read = (s1_op == dmct_pkg::OP_FETCH) || (s1_op == dmct_pkg::OP_LOAD);
  assign fill    = advance && is_read && !hit;

  assign ram_we    = clearing || fill;
  assign ram_waddr = clearing ? clear_ptr : s1_idx;
  assign ram_wdata = clearing ? '0 : {1'b1, s1_tag};

  assign evt_valid    = s1_valid;
  assign evt.is_read  = is_read;
  assign evt.is_fetch = (s1_op == dmct_pkg::OP_FETCH);
  assign evt.hit      = hit;
  assign evt.stall    = is_read ? (hit ? '0 : read_miss_penalty) : write_penalty;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clear_ptr <= '0;
      s1_valid  <= 1'b0;
      fwd_valid <= 1'b0;
    end else begin
      if (clearing) begin
        clear_ptr <= clear_ptr + 1'b1;
        if (clear_ptr == LAST_LINE) begin
          clearing <= 1'b0;
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (fill) begin
        fwd_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op  <= op;
      s1_idx <= in_idx;
      s1_tag <= in_tag;
    end
    if (fill) begin
      fwd_idx <= s1_idx;
      fwd_tag <= s1_tag;
    end
  end

endmodule

@@ rtl/core/dmct_stats.sv @@
// Saturating access counters and the result output register.
module dmct_stats (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          evt_valid,
  output logic                          evt_ready,
  input  dmct_pkg::dmct_event_t         evt,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          hit,
  output logic [dmct_pkg::PEN_W-1:0]    stall_cycles,
  output logic [dmct_pkg::CNT_W-1:0]    read_hit_count,
  output logic [dmct_pkg::CNT_W-1:0]    read_miss_count,
  output logic [dmct_pkg::CNT_W-1:0]    write_hit_count,
  output logic [dmct_pkg::CNT_W-1:0]    write_miss_count,
  output logic [dmct_pkg::CNT_W-1:0]    read_stall_total,
  output logic [dmct_pkg::CNT_W-1:0]    write_stall_total,
  output logic [dmct_pkg::CNT_W-1:0]    fetch_count
);

  localparam int CNT_W = dmct_pkg::CNT_W;

  logic             take;
  logic [CNT_W:0]   stall_sum;
  logic [CNT_W-1:0] stall_total;
  logic [CNT_W-1:0] stall_total_next;

  // the output registers double as the running counters
  assign evt_ready = !out_valid || out_ready;
  assign take      = evt_valid && evt_ready;

  assign stall_total      = evt.is_read ? read_stall_total : write_stall_total;
  assign stall_sum        = {1'b0, stall_total} + (CNT_W + 1)'(evt.stall);
  assign stall_total_next = stall_sum[CNT_W] ? '1 : stall_sum[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid         <= 1'b0;
      read_hit_count    <= '0;
      read_miss_count   <= '0;
      write_hit_count   <= '0;
      write_miss_count  <= '0;
      read_stall_total  <= '0;
      write_stall_total <= '0;
      fetch_count       <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (take) begin
        if (evt.is_read) begin
          read_stall_total <= stall_total_next;
          if (evt.hit) begin
            if (read_hit_count != '1) read_hit_count <= read_hit_count + 1'b1;
          end else begin
            if (read_miss_count != '1) read_miss_count <= read_miss_count + 1'b1;
          end
          if (evt.is_fetch && (fetch_count != '1)) begin
            fetch_count <= fetch_count + 1'b1;
          end
        end else begin
          write_stall_total <= stall_total_next;
          if (evt.hit) begin
            if (write_hit_count != '1) write_hit_count <= write_hit_count + 1'b1;
          end else begin
            if (write_miss_count != '1) write_miss_count <= write_miss_count + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hit          <= evt.hit;
      stall_cycles <= evt.stall;
    end
  end

endmodule
